/* src/zrle_pkg.sv */
// Shared constants and types of the zero-run / literal run-length encoder.
`timescale 1ns / 1ps

package zrle_pkg;

  // Longest zero run or literal run before it is split or closed
  localparam int unsigned MAX_RUN = 128;

  // Run counters hold 0..MAX_RUN, the literal store is indexed 0..MAX_RUN-1
  localparam int unsigned CNT_W  = $clog2(MAX_RUN + 1);
  localparam int unsigned ADDR_W = $clog2(MAX_RUN);

  // Output word packing
  localparam int unsigned WORD_BYTES = 8;
  localparam int unsigned LANE_W     = $clog2(WORD_BYTES);
  localparam int unsigned COUNT_W    = 4;

  // Literal run header: base plus (length - 1)
  localparam logic [7:0] LIT_CODE_BASE = 8'h80;

  // One compressed byte on its way from the sequencer to the packer
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
    logic       stream_end;
  } zrle_byte_t;

endpackage

/* src/zrle_ifs.sv */
// Valid/ready channel interfaces for plane bytes in and packed words out.
`timescale 1ns / 1ps

interface zrle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       plane_end;

  modport source (output valid, output data_byte, output plane_end, input ready);
  modport sink   (input valid, input data_byte, input plane_end, output ready);
endinterface

interface zrle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte0;
  logic [7:0] out_byte1;
  logic [7:0] out_byte2;
  logic [7:0] out_byte3;
  logic [7:0] out_byte4;
  logic [7:0] out_byte5;
  logic [7:0] out_byte6;
  logic [7:0] out_byte7;
  logic [3:0] byte_count;
  logic       word_last;
  logic       stream_end;

  modport source (
    output valid, output out_byte0, output out_byte1, output out_byte2, output out_byte3,
    output out_byte4, output out_byte5, output out_byte6, output out_byte7,
    output byte_count, output word_last, output stream_end, input ready
  );
  modport sink (
    input valid, input out_byte0, input out_byte1, input out_byte2, input out_byte3,
    input out_byte4, input out_byte5, input out_byte6, input out_byte7,
    input byte_count, input word_last, input stream_end, output ready
  );
endinterface

/* src/zero_run_literal_rle_encoder.sv */
// Top level of the zero-run / literal run-length encoder for one byte plane.
//
// Usage: plane bytes enter on in_i (data_byte, plane_end on the final byte).
// Compressed bytes leave on out_o packed up to eight per word, with
// byte_count valid bytes, word_last on the last word of a transaction and
// stream_end on the last word of the plane's final byte.
// Timing: a byte that only extends an open run starts no emission, so such
// bytes stream at one per cycle. A byte that closes runs emits its B
// compressed bytes at one byte per cycle unless the output stalls, since the
// open literal run is read back from the literal store through its single
// read port; no further input byte is taken until all B bytes have left the
// byte stage. One byte emits at most 129 bytes (a full literal run and its
// code byte), that is 17 words.
// The store is written only on acceptance and read only while emitting, so
// in_i.ready, low during emission, keeps the two apart.
// Reset: all runs are empty; the store needs no clearing since every entry
// is written before it is read.
// Stall: a full word waits in the output register while the next word is
// packed; when that one completes too, emission pauses until out_o.ready.
`timescale 1ns / 1ps

module zero_run_literal_rle_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  zrle_in_if.sink    in_i,
  zrle_out_if.source out_o
);
  import zrle_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ZPRE  = 3'd1;
  localparam logic [2:0] ST_LCODE = 3'd2;
  localparam logic [2:0] ST_LIT   = 3'd3;
  localparam logic [2:0] ST_ZPOST = 3'd4;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RUN);

  // Literal store
  logic [7:0]        lit_mem [MAX_RUN];
  logic [7:0]        rd_q;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              rd_en;

  // Run state
  logic [CNT_W-1:0] lit_cnt_q, lit_cnt_d;
  logic [CNT_W-1:0] zero_cnt_q, zero_cnt_d;
  logic             zero_held_q, zero_held_d;

  // Emission plan of the accepted byte
  logic             zpre_en, zpre_en_q;
  logic [7:0]       zpre_val, zpre_val_q;
  logic             lit_en, lit_en_q;
  logic [CNT_W-1:0] lit_len, lit_len_q;
  logic             zpost_en, zpost_en_q;
  logic [7:0]       zpost_val, zpost_val_q;
  logic             end_q;

  // Sequencer and byte stage
  logic [2:0]        st_q, st_d;
  logic [ADDR_W-1:0] rd_cnt_q, rd_cnt_d;
  logic              s2_valid_q, s2_valid_d;
  logic              s2_mem_q, s2_mem_d;
  logic [7:0]        s2_byte_q, s2_byte_d;
  logic              s2_last_q, s2_last_d;
  logic              advance;
  logic              accept;
  logic              nz;
  logic [CNT_W-1:0]  lc_p1, lc_p2;
  logic              rd_last;
  zrle_byte_t        pk_byte;

  assign in_i.ready = (st_q == ST_IDLE) && !s2_valid_q;
  assign accept     = in_i.valid && in_i.ready;
  assign nz         = |in_i.data_byte;
  assign lc_p1      = lit_cnt_q + CNT_W'(1);
  assign lc_p2      = lit_cnt_q + CNT_W'(2);

  // Run update and emission plan for one plane byte
  always_comb begin
    lit_cnt_d   = lit_cnt_q;
    zero_cnt_d  = zero_cnt_q;
    zero_held_d = zero_held_q;
    zpre_en     = 1'b0;
    zpre_val    = '0;
    lit_en      = 1'b0;
    lit_len     = '0;
    zpost_en    = 1'b0;
    zpost_val   = '0;
    wr_en       = 1'b0;
    wr_addr     = lit_cnt_q[ADDR_W-1:0];
    wr_data     = in_i.data_byte;

    if (zero_cnt_q != '0) begin
      // open zero run
      if (!nz) begin
        if (zero_cnt_q + CNT_W'(1) >= MAX_CNT) begin
          zpre_en    = 1'b1;
          zpre_val   = 8'(MAX_CNT - CNT_W'(1));
          zero_cnt_d = '0;
        end else begin
          zero_cnt_d = zero_cnt_q + CNT_W'(1);
        end
      end else begin
        zpre_en    = 1'b1;
        zpre_val   = 8'(zero_cnt_q - CNT_W'(1));
        zero_cnt_d = '0;
        wr_en      = 1'b1;
        wr_addr    = '0;
        lit_cnt_d  = CNT_W'(1);
      end
    end else if (lit_cnt_q != '0) begin
      if (zero_held_q) begin
        // held zero already sits in the store at lit_cnt
        zero_held_d = 1'b0;
        if (nz) begin
          wr_en   = 1'b1;
          wr_addr = lc_p1[ADDR_W-1:0];
          if (lc_p2 >= MAX_CNT) begin
            lit_en    = 1'b1;
            lit_len   = lc_p2;
            lit_cnt_d = '0;
          end else begin
            lit_cnt_d = lc_p2;
          end
        end else begin
          lit_en    = 1'b1;
          lit_len   = lit_cnt_q;
          lit_cnt_d = '0;
          if (MAX_CNT <= CNT_W'(2)) begin
            zpost_en   = 1'b1;
            zpost_val  = 8'd1;
            zero_cnt_d = '0;
          end else begin
            zero_cnt_d = CNT_W'(2);
          end
        end
      end else if (nz) begin
        wr_en = 1'b1;
        if (lc_p1 >= MAX_CNT) begin
          lit_en    = 1'b1;
          lit_len   = lc_p1;
          lit_cnt_d = '0;
        end else begin
          lit_cnt_d = lc_p1;
        end
      end else if (lc_p1 < MAX_CNT) begin
        // hold the zero, written speculatively into the run
        zero_held_d = 1'b1;
        wr_en       = 1'b1;
      end else begin
        // zero at the literal limit
        lit_en     = 1'b1;
        lit_len    = lit_cnt_q;
        lit_cnt_d  = '0;
        zero_cnt_d = CNT_W'(1);
      end
    end else begin
      if (!nz) begin
        zero_cnt_d = CNT_W'(1);
      end else begin
        wr_en     = 1'b1;
        lit_cnt_d = CNT_W'(1);
      end
    end

    // plane end flushes everything that is open
    if (in_i.plane_end) begin
      if (zero_held_d) begin
        zero_held_d = 1'b0;
        lit_en      = 1'b1;
        lit_len     = lit_cnt_d;
        lit_cnt_d   = '0;
        zpost_en    = 1'b1;
        zpost_val   = 8'd0;
      end else begin
        if (lit_cnt_d != '0) begin
          lit_en    = 1'b1;
          lit_len   = lit_cnt_d;
          lit_cnt_d = '0;
        end
        if (zero_cnt_d != '0) begin
          zpost_en   = 1'b1;
          zpost_val  = 8'(zero_cnt_d - CNT_W'(1));
          zero_cnt_d = '0;
        end
      end
    end
  end

  // Run state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lit_cnt_q   <= '0;
      zero_cnt_q  <= '0;
      zero_held_q <= 1'b0;
    end else if (accept) begin
      lit_cnt_q   <= lit_cnt_d;
      zero_cnt_q  <= zero_cnt_d;
      zero_held_q <= zero_held_d;
    end
  end

  // Plan registers, loaded on acceptance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zpre_en_q  <= 1'b0;
      lit_en_q   <= 1'b0;
      zpost_en_q <= 1'b0;
      end_q      <= 1'b0;
    end else if (accept) begin
      zpre_en_q  <= zpre_en;
      lit_en_q   <= lit_en;
      zpost_en_q <= zpost_en;
      end_q      <= in_i.plane_end;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      zpre_val_q  <= zpre_val;
      lit_len_q   <= lit_len;
      zpost_val_q <= zpost_val;
    end
  end

  // Literal store: one write on acceptance, one registered read while emitting
  always_ff @(posedge clk_i) begin
    if (wr_en && accept) begin
      lit_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= lit_mem[rd_cnt_q];
    end
  end

  assign rd_last = ({1'b0, rd_cnt_q} + CNT_W'(1)) == lit_len_q;

  // Sequencer: one compressed byte per cycle into the byte stage while advance is high
  always_comb begin
    st_d       = st_q;
    rd_cnt_d   = rd_cnt_q;
    s2_valid_d = s2_valid_q;
    s2_mem_d   = s2_mem_q;
    s2_byte_d  = s2_byte_q;
    s2_last_d  = s2_last_q;
    rd_en      = 1'b0;
    if (advance) begin
      s2_valid_d = 1'b0;
      s2_mem_d   = 1'b0;
      unique case (st_q)
        ST_IDLE: begin
          if (accept) begin
            priority if (zpre_en) begin
              st_d = ST_ZPRE;
            end else if (lit_en) begin
              st_d = ST_LCODE;
            end else if (zpost_en) begin
              st_d = ST_ZPOST;
            end else begin
              st_d = ST_IDLE;
            end
          end
        end
        ST_ZPRE: begin
          s2_valid_d = 1'b1;
          s2_byte_d  = zpre_val_q;
          s2_last_d  = !lit_en_q && !zpost_en_q;
          st_d       = lit_en_q ? ST_LCODE : (zpost_en_q ? ST_ZPOST : ST_IDLE);
        end
        ST_LCODE: begin
          s2_valid_d = 1'b1;
          s2_byte_d  = LIT_CODE_BASE + 8'(lit_len_q - CNT_W'(1));
          s2_last_d  = 1'b0;
          rd_cnt_d   = '0;
          st_d       = ST_LIT;
        end
        ST_LIT: begin
          rd_en      = 1'b1;
          s2_valid_d = 1'b1;
          s2_mem_d   = 1'b1;
          s2_last_d  = rd_last && !zpost_en_q;
          if (rd_last) begin
            st_d = zpost_en_q ? ST_ZPOST : ST_IDLE;
          end else begin
            rd_cnt_d = rd_cnt_q + ADDR_W'(1);
          end
        end
        ST_ZPOST: begin
          s2_valid_d = 1'b1;
          s2_byte_d  = zpost_val_q;
          s2_last_d  = 1'b1;
          st_d       = ST_IDLE;
        end
        default: begin
          st_d = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      s2_valid_q <= 1'b0;
    end else begin
      st_q       <= st_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_cnt_q  <= rd_cnt_d;
    s2_mem_q  <= s2_mem_d;
    s2_byte_q <= s2_byte_d;
    s2_last_q <= s2_last_d;
  end

  // Byte stage toward the packer
  always_comb begin
    pk_byte.valid      = s2_valid_q;
    pk_byte.data       = s2_mem_q ? rd_q : s2_byte_q;
    pk_byte.last       = s2_last_q;
    pk_byte.stream_end = s2_last_q && end_q;
  end

  zrle_packer u_packer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_i    (pk_byte),
    .advance_o (advance),
    .out_o     (out_o)
  );

  // A held zero needs an open literal run and no zero run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    zero_held_q |-> lit_cnt_q != '0 && zero_cnt_q == '0)
    else $error("held zero without open literal run");

  // Runs never rest at the limit, and only one kind is open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lit_cnt_q < MAX_CNT && zero_cnt_q < MAX_CNT && (lit_cnt_q == '0 || zero_cnt_q == '0))
    else $error("run counters out of range");

  // Literal readback stays inside the planned run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_LIT |-> lit_en_q && ({1'b0, rd_cnt_q} < lit_len_q))
    else $error("literal read beyond run length");

endmodule

/* src/zrle_packer.sv */
// Packs the compressed byte stream into output words of up to eight bytes.
`timescale 1ns / 1ps

module zrle_packer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  zrle_pkg::zrle_byte_t byte_i,
  output logic               advance_o,
  zrle_out_if.source         out_o
);
  import zrle_pkg::*;

  logic [WORD_BYTES-1:0][7:0] pack_q, pack_d;
  logic [WORD_BYTES-1:0][7:0] word_now;
  logic [LANE_W-1:0]          lane_q, lane_d;
  logic                       out_valid_q, out_valid_d;
  logic [WORD_BYTES-1:0][7:0] out_word_q;
  logic [COUNT_W-1:0]         out_count_q;
  logic                       out_last_q;
  logic                       out_end_q;
  logic                       done;
  logic                       out_busy;
  logic                       take;

  // A word closes when its last lane fills or the transaction's last byte lands
  assign done     = byte_i.valid && (lane_q == LANE_W'(WORD_BYTES - 1) || byte_i.last);
  assign out_busy = out_valid_q && !out_o.ready;
  assign advance_o = !(done && out_busy);
  assign take     = byte_i.valid && advance_o;

  // Current partial word with the incoming byte merged in
  always_comb begin
    word_now         = pack_q;
    word_now[lane_q] = byte_i.data;
  end

  // Next state of the pack buffer and output valid
  always_comb begin
    pack_d      = pack_q;
    lane_d      = lane_q;
    out_valid_d = out_valid_q && !out_o.ready;
    if (take) begin
      if (done) begin
        pack_d      = '0;
        lane_d      = '0;
        out_valid_d = 1'b1;
      end else begin
        pack_d = word_now;
        lane_d = lane_q + LANE_W'(1);
      end
    end
  end

  // Control registers; the pack buffer is cleared so unused lanes read zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pack_q      <= '0;
      lane_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pack_q      <= pack_d;
      lane_q      <= lane_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output word payload
  always_ff @(posedge clk_i) begin
    if (take && done) begin
      out_word_q  <= word_now;
      out_count_q <= {1'b0, lane_q} + COUNT_W'(1);
      out_last_q  <= byte_i.last;
      out_end_q   <= byte_i.stream_end;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_byte0  = out_word_q[0];
  assign out_o.out_byte1  = out_word_q[1];
  assign out_o.out_byte2  = out_word_q[2];
  assign out_o.out_byte3  = out_word_q[3];
  assign out_o.out_byte4  = out_word_q[4];
  assign out_o.out_byte5  = out_word_q[5];
  assign out_o.out_byte6  = out_word_q[6];
  assign out_o.out_byte7  = out_word_q[7];
  assign out_o.byte_count = out_count_q;
  assign out_o.word_last  = out_last_q;
  assign out_o.stream_end = out_end_q;

  // A stall freezes the partial word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_o |=> $stable(lane_q) && $stable(pack_q))
    else $error("pack buffer changed during stall");

  // Only the last word of a transaction may be short
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_last_q |-> out_count_q == COUNT_W'(WORD_BYTES))
    else $error("short word before end of transaction");

  // End of stream is flagged only on a transaction's last word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_end_q |-> out_last_q)
    else $error("stream_end without word_last");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench of the zero-run / literal run-length encoder.
`timescale 1ns / 1ps

module tb_top;
  import zrle_pkg::*;

  // One plane byte waiting to be sent
  typedef struct {
    logic [7:0] data;
    logic       plane_end;
    bit         calm;
  } plane_item_t;

  // One packed output word
  typedef struct {
    logic [7:0] lane [WORD_BYTES];
    logic [3:0] count;
    logic       word_last;
    logic       stream_end;
  } packed_word_t;

  logic clk_i;
  logic rst_ni;

  zrle_in_if  in_if ();
  zrle_out_if out_if ();

  zero_run_literal_rle_encoder u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  plane_item_t  plane_q [$];
  packed_word_t coded_words_q [$];
  int unsigned  err_cnt;

  // Encoder image: open literal run, held zero, open zero run
  logic [7:0]  lit_mem [MAX_RUN];
  int unsigned lit_len;
  bit          zero_pending;
  int unsigned zrun_len;
  logic [7:0]  code_q [$];

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Reset, asserted once
  initial begin
    rst_ni <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("[zero_run_literal_rle_encoder] ERROR");
    $finish;
  end

  task close_literal();
    if (lit_len != 0) begin
      code_q.push_back(LIT_CODE_BASE + 8'(lit_len - 1));
      for (int k = 0; k < lit_len; k++) code_q.push_back(lit_mem[ADDR_W'(k)]);
      lit_len = 0;
    end
  endtask

  task close_zeros();
    if (zrun_len != 0) begin
      code_q.push_back(8'(zrun_len - 1));
      zrun_len = 0;
    end
  endtask

  task add_literal(input logic [7:0] b);
    lit_mem[ADDR_W'(lit_len)] = b;
    lit_len++;
    if (lit_len >= MAX_RUN) close_literal();
  endtask

  task add_zero();
    zrun_len++;
    if (zrun_len >= MAX_RUN) close_zeros();
  endtask

  // Work out the compressed words caused by one accepted plane byte
  task automatic encode_item(input logic [7:0] b, input logic fin);
    int unsigned  n_words;
    int unsigned  n;
    packed_word_t w;
    code_q.delete();
    if (zrun_len > 0) begin
      if (b == 8'd0) begin
        add_zero();
      end else begin
        close_zeros();
        add_literal(b);
      end
    end else if (lit_len > 0) begin
      if (zero_pending) begin
        zero_pending = 1'b0;
        if (b != 8'd0) begin
          add_literal(8'd0);
          add_literal(b);
        end else begin
          close_literal();
          add_zero();
          add_zero();
        end
      end else if (b != 8'd0) begin
        add_literal(b);
      end else if (lit_len + 1 < MAX_RUN) begin
        zero_pending = 1'b1;
      end else begin
        // zero would land on the last allowed literal slot
        close_literal();
        add_zero();
      end
    end else if (b == 8'd0) begin
      add_zero();
    end else begin
      add_literal(b);
    end
    if (fin) begin
      if (zero_pending) begin
        zero_pending = 1'b0;
        close_literal();
        add_zero();
      end
      close_literal();
      close_zeros();
    end
    // pack up to eight bytes per word
    n_words = (code_q.size() + WORD_BYTES - 1) / WORD_BYTES;
    for (int wi = 0; wi < n_words; wi++) begin
      n = code_q.size() - wi * WORD_BYTES;
      if (n > WORD_BYTES) n = WORD_BYTES;
      for (int k = 0; k < WORD_BYTES; k++)
        w.lane[LANE_W'(k)] = (k < n) ? code_q[wi * WORD_BYTES + k] : 8'd0;
      w.count      = 4'(n);
      w.word_last  = (wi + 1 == n_words);
      w.stream_end = fin && (wi + 1 == n_words);
      coded_words_q.push_back(w);
    end
  endtask

  task push_byte(input logic [7:0] b, input logic fin, input bit calm);
    plane_item_t it;
    it.data      = b;
    it.plane_end = fin;
    it.calm      = calm;
    plane_q.push_back(it);
  endtask

  // A run of zeros or of random nonzero bytes; plane_end on its last byte if asked
  task push_run(input int len, input bit zeros, input bit fin, input bit calm);
    for (int k = 0; k < len; k++)
      push_byte(zeros ? 8'd0 : 8'($urandom_range(1, 255)), fin && (k == len - 1), calm);
  endtask

  // Random plane of short runs, or plain noise bytes
  task push_random_plane(input bit calm, output int cnt);
    int nseg;
    int len;
    cnt = 0;
    if ($urandom_range(0, 7) == 0) begin
      len = $urandom_range(1, 12);
      for (int k = 0; k < len; k++)
        push_byte(($urandom_range(0, 9) < 3) ? 8'd0 : 8'($urandom), k == len - 1, calm);
      cnt = len;
    end else begin
      nseg = $urandom_range(1, 6);
      for (int s = 0; s < nseg; s++) begin
        if ($urandom_range(0, 2) == 0) len = $urandom_range(1, 6);
        else len = $urandom_range(1, 8);
        push_run(len, $urandom_range(0, 2) == 0, s == nseg - 1, calm);
        cnt += len;
      end
    end
  endtask

  // Driver: feeds plane bytes, predicts on each accepted transaction
  bit          calm_phase;
  int unsigned gap_left;
  plane_item_t next_item;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.data_byte <= 8'd0;
      in_if.plane_end <= 1'b0;
      gap_left        <= 0;
      calm_phase      <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) encode_item(in_if.data_byte, in_if.plane_end);
      if (in_if.valid && !in_if.ready) begin
        // hold the offered byte
      end else if (gap_left > 0) begin
        gap_left    <= gap_left - 1;
        in_if.valid <= 1'b0;
      end else if (plane_q.size() > 0 && !plane_q[0].calm && $urandom_range(0, 5) == 0) begin
        gap_left    <= $urandom_range(0, 4);
        in_if.valid <= 1'b0;
      end else if (plane_q.size() > 0) begin
        next_item       = plane_q.pop_front();
        in_if.valid     <= 1'b1;
        in_if.data_byte <= next_item.data;
        in_if.plane_end <= next_item.plane_end;
        calm_phase      <= next_item.calm;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: random back-pressure, checks each word against the oldest prediction
  int unsigned  stall_left;
  packed_word_t got;
  packed_word_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got.lane[0]    = out_if.out_byte0;
        got.lane[1]    = out_if.out_byte1;
        got.lane[2]    = out_if.out_byte2;
        got.lane[3]    = out_if.out_byte3;
        got.lane[4]    = out_if.out_byte4;
        got.lane[5]    = out_if.out_byte5;
        got.lane[6]    = out_if.out_byte6;
        got.lane[7]    = out_if.out_byte7;
        got.count      = out_if.byte_count;
        got.word_last  = out_if.word_last;
        got.stream_end = out_if.stream_end;
        if (coded_words_q.size() == 0) begin
          $error("output word with no prediction pending");
          err_cnt++;
        end else begin
          want = coded_words_q.pop_front();
          for (int k = 0; k < WORD_BYTES; k++) begin
            if (got.lane[LANE_W'(k)] !== want.lane[LANE_W'(k)]) begin
              $error("out_byte%0d expected %0h actual %0h", k, want.lane[LANE_W'(k)],
                     got.lane[LANE_W'(k)]);
              err_cnt++;
            end
          end
          if (got.count !== want.count) begin
            $error("byte_count expected %0d actual %0d", want.count, got.count);
            err_cnt++;
          end
          if (got.word_last !== want.word_last) begin
            $error("word_last expected %0b actual %0b", want.word_last, got.word_last);
            err_cnt++;
          end
          if (got.stream_end !== want.stream_end) begin
            $error("stream_end expected %0b actual %0b", want.stream_end, got.stream_end);
            err_cnt++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left   <= stall_left - 1;
        out_if.ready <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
        stall_left   <= $urandom_range(0, 4);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int rnd_items;
    int cnt;
    err_cnt      = 0;
    lit_len      = 0;
    zero_pending = 1'b0;
    zrun_len     = 0;

    // lone zero, lone 0xFF
    push_byte(8'h00, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b1, 1'b0);
    // held zero joins the literal run
    push_byte(8'h01, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h02, 1'b1, 1'b0);
    // held zero then zero closes the literals and opens a zero run of two
    push_byte(8'h03, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h05, 1'b1, 1'b0);
    // held zero at plane end
    push_byte(8'h07, 1'b0, 1'b0);
    push_byte(8'h00, 1'b1, 1'b0);
    // zeros, literal, trailing held zero
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h09, 1'b0, 1'b0);
    push_byte(8'h00, 1'b1, 1'b0);
    // bit patterns
    push_byte(8'h80, 1'b0, 1'b0);
    push_byte(8'h7F, 1'b0, 1'b0);
    push_byte(8'hAA, 1'b0, 1'b0);
    push_byte(8'h55, 1'b1, 1'b0);

    // random planes of short runs
    rnd_items = 0;
    while (rnd_items < 80) begin
      push_random_plane(1'b0, cnt);
      rnd_items += cnt;
    end

    // closing stretch without idling
    rnd_items = 0;
    while (rnd_items < 20) begin
      push_random_plane(1'b1, cnt);
      rnd_items += cnt;
    end

    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    while (plane_q.size() != 0 || in_if.valid || coded_words_q.size() != 0)
      @(posedge clk_i);
    repeat (150) @(posedge clk_i);

    if (err_cnt == 0 && coded_words_q.size() == 0) begin
      $display("[zero_run_literal_rle_encoder] OK");
    end else begin
      $display("[zero_run_literal_rle_encoder] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/zrle_pkg.sv
src/zrle_ifs.sv
src/zrle_packer.sv
src/zero_run_literal_rle_encoder.sv
tb/tb_top.sv
